>>> rtl/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Types and constants shared by the chunk directory modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdb_pkg;

    localparam int OFFSET_W = 24;
    localparam int ROWS_W   = 24;
    localparam int SLOT_OW  = 10;
    localparam int COUNT_OW = 11;

    localparam logic [ROWS_W-1:0] BUDGET_RESET = 24'd5298068;

    typedef enum logic [2:0] {
        ST_NEW         = 3'd0,
        ST_OVERWRITE   = 3'd1,
        ST_OVER_BUDGET = 3'd2,
        ST_FULL        = 3'd3,
        ST_HIT         = 3'd4,
        ST_MISS        = 3'd5
    } status_t;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_FETCH = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SEARCH,
        CS_DECIDE
    } ctrl_state_t;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  layer_index;
        logic [23:0] first_row;
        logic [15:0] rows_in_chunk;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot_index;
        logic [23:0] payload_offset;
        logic [10:0] entries_held;
        logic [23:0] rows_held_now;
    } out_item_t;

    // Lookup key as stored in a cell and carried by the probe.
    typedef struct packed {
        logic [7:0]  layer;
        logic [23:0] first_row;
        logic [15:0] num_rows;
    } key_t;

    // Probe token travelling down the cell chain.
    typedef struct packed {
        logic                live;
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } probe_t;

endpackage

`default_nettype wire

>>> rtl/chunk_directory_with_budget.sv
// ----------------------------------------------------------------------------
// chunk_directory_with_budget
// Exact-match chunk directory with a row budget, built as a chain of slots.
//
// Usage:
//   in_*   : request channel (valid/stall), one in_item_t per transfer.
//   out_*  : result channel (valid/stall), one out_item_t per request.
//   cfg_*  : budget_rows write channel (valid/ready), always ready.
// A request is compared in slot 0 at its accepting edge and moves one slot
// per cycle; the result leaving the last slot is latched, and the decide
// step then loads the output register, once the output can take it.
// One request is in flight at a time: the next one is accepted only after
// the block has returned to its idle step.
// The next request is accepted while a result still waits in the output
// register; a result stalled at the output holds the block in its decide step.
// Reset empties the directory (count and rows held to zero) and loads the
// budget with its default. Slot contents are not cleared; slots at or above
// the entry count can never match a probe.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_directory_with_budget #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  cdb_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  wire                          out_stall,
    output cdb_pkg::out_item_t           out_data,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [cdb_pkg::ROWS_W-1:0]   cfg_data
);
    import cdb_pkg::*;

    localparam int SLOT_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_XW  = (SLOT_W > SLOT_OW) ? SLOT_W : SLOT_OW;
    localparam int CNT_XW   = (CNT_W > COUNT_OW) ? CNT_W : COUNT_OW;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Chain wiring
    key_t              chain_key   [0:TABLE_DEPTH];
    probe_t            chain_probe [0:TABLE_DEPTH];
    logic [SLOT_W-1:0] chain_slot  [0:TABLE_DEPTH];

    // Control and state
    ctrl_state_t         state_reg;
    ctrl_state_t         state_next;
    logic [ROWS_W-1:0]   budget_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [ROWS_W-1:0]   rows_reg;
    logic [ROWS_W-1:0]   rows_next;

    in_item_t            req_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_reg;
    out_item_t           out_next;

    logic                accept;
    logic                capture;
    logic                out_free;
    logic                finish;
    logic                over_budget;
    logic                table_full;
    logic                wr_en;
    key_t                req_key;
    logic [ROWS_W:0]     rows_sum;
    status_t             status;
    logic [SLOT_W-1:0]   res_slot;
    logic [OFFSET_W-1:0] res_offset;
    logic [SLOT_XW-1:0]  slot_ext;
    logic [CNT_XW-1:0]   count_ext;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Head of the chain takes the request straight from the input port.
    assign chain_key[0].layer       = in_data.layer_index;
    assign chain_key[0].first_row   = in_data.first_row;
    assign chain_key[0].num_rows    = in_data.rows_in_chunk;
    assign chain_probe[0].live      = accept;
    assign chain_probe[0].found     = 1'b0;
    assign chain_probe[0].offset    = '0;
    assign chain_slot[0]            = '0;

    assign req_key.layer     = req_reg.layer_index;
    assign req_key.first_row = req_reg.first_row;
    assign req_key.num_rows  = req_reg.rows_in_chunk;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            cdb_cell #(
                .IDX    (gi),
                .SLOT_W (SLOT_W),
                .CNT_W  (CNT_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .key_in      (chain_key[gi]),
                .probe_in    (chain_probe[gi]),
                .slot_in     (chain_slot[gi]),
                .key_out     (chain_key[gi+1]),
                .probe_out   (chain_probe[gi+1]),
                .slot_out    (chain_slot[gi+1]),
                .entry_count (count_reg),
                .wr_en       (wr_en),
                .wr_slot     (count_reg[SLOT_W-1:0]),
                .wr_key      (req_key),
                .wr_offset   (rows_reg)
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                    state_next = CS_SEARCH;
            end
            CS_SEARCH:
            begin
                if (chain_probe[TABLE_DEPTH].live)
                    state_next = CS_DECIDE;
            end
            CS_DECIDE:
            begin
                if (out_free)
                    state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall = 1'b1;
        capture  = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            CS_IDLE:   in_stall = 1'b0;
            CS_SEARCH: capture  = chain_probe[TABLE_DEPTH].live;
            CS_DECIDE: finish   = out_free;
            default:   in_stall = 1'b1;
        endcase
    end

    // Decision on the probe result
    assign rows_sum    = {1'b0, rows_reg} + (ROWS_W + 1)'(req_reg.rows_in_chunk);
    assign over_budget = rows_sum > {1'b0, budget_reg};
    assign table_full  = count_reg >= DEPTH_CNT;

    always_comb
    begin
        wr_en      = 1'b0;
        res_slot   = '0;
        res_offset = '0;
        count_next = count_reg;
        rows_next  = rows_reg;
        if (req_reg.opcode == OP_FETCH)
        begin
            if (found_reg)
            begin
                status     = ST_HIT;
                res_slot   = slot_reg;
                res_offset = offset_reg;
            end
            else
            begin
                status = ST_MISS;
            end
        end
        else if (found_reg)
        begin
            status     = ST_OVERWRITE;
            res_slot   = slot_reg;
            res_offset = offset_reg;
        end
        else if (over_budget)
        begin
            status = ST_OVER_BUDGET;
        end
        else if (table_full)
        begin
            status = ST_FULL;
        end
        else
        begin
            status     = ST_NEW;
            wr_en      = finish;
            res_slot   = count_reg[SLOT_W-1:0];
            res_offset = rows_reg;
            count_next = count_reg + CNT_W'(1);
            rows_next  = rows_sum[ROWS_W-1:0];
        end
    end

    assign slot_ext  = SLOT_XW'(res_slot);
    assign count_ext = CNT_XW'(count_next);

    always_comb
    begin
        out_next.status         = status;
        out_next.slot_index     = slot_ext[SLOT_OW-1:0];
        out_next.payload_offset = res_offset;
        out_next.entries_held   = count_ext[COUNT_OW-1:0];
        out_next.rows_held_now  = rows_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            budget_reg    <= BUDGET_RESET;
            count_reg     <= '0;
            rows_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                budget_reg <= cfg_data;
            if (finish)
            begin
                count_reg <= count_next;
                rows_reg  <= rows_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_data;
        if (capture)
        begin
            found_reg  <= chain_probe[TABLE_DEPTH].found;
            slot_reg   <= chain_slot[TABLE_DEPTH];
            offset_reg <= chain_probe[TABLE_DEPTH].offset;
        end
        if (finish)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> rtl/cdb_cell.sv
// ----------------------------------------------------------------------------
// cdb_cell
// One directory slot. Holds a key and its payload offset, compares the probe
// passing through against it and hands the probe to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cdb_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 10,
    parameter int CNT_W  = 11
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  cdb_pkg::key_t                key_in,
    input  cdb_pkg::probe_t              probe_in,
    input  wire  [SLOT_W-1:0]            slot_in,
    output cdb_pkg::key_t                key_out,
    output cdb_pkg::probe_t              probe_out,
    output logic [SLOT_W-1:0]            slot_out,
    input  wire  [CNT_W-1:0]             entry_count,
    input  wire                          wr_en,
    input  wire  [SLOT_W-1:0]            wr_slot,
    input  cdb_pkg::key_t                wr_key,
    input  wire  [cdb_pkg::OFFSET_W-1:0] wr_offset
);
    import cdb_pkg::*;

    localparam logic [CNT_W-1:0]  MY_CNT  = CNT_W'(IDX);
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    key_t                entry_key_reg;
    logic [OFFSET_W-1:0] entry_offset_reg;

    key_t                key_reg;
    logic                live_reg;
    logic                found_reg;
    logic [OFFSET_W-1:0] offset_reg;
    probe_t              probe_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                hit;

    // Slots are filled from zero upward, so a slot is valid below the count.
    assign hit = probe_in.live && (MY_CNT < entry_count) && (entry_key_reg == key_in);

    always_comb
    begin
        probe_next.live  = probe_in.live;
        probe_next.found = probe_in.found | hit;
        probe_next.offset = hit ? entry_offset_reg : probe_in.offset;
        slot_next = hit ? MY_SLOT : slot_in;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_slot == MY_SLOT))
        begin
            entry_key_reg    <= wr_key;
            entry_offset_reg <= wr_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= probe_next.live;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg            <= key_in;
        found_reg          <= probe_next.found;
        offset_reg         <= probe_next.offset;
        slot_reg           <= slot_next;
    end

    assign key_out   = key_reg;
    assign probe_out = '{live: live_reg, found: found_reg, offset: offset_reg};
    assign slot_out  = slot_reg;

endmodule

`default_nettype wire
